// File: rtl/paced_can_transmit_queue_assert.svh
// Assertion macros for the paced CAN transmit queue.
// Depends on nothing; included by the RTL files that carry checks.
`ifndef PACED_CAN_TRANSMIT_QUEUE_ASSERT_SVH
`define PACED_CAN_TRANSMIT_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PCTQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pctq: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define PCTQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pctq: next-cycle check failed");

`endif

// File: rtl/pctq_pkg.sv
// Shared types and constants for the paced CAN transmit queue.
// No dependencies; used by pctq_ring and paced_can_transmit_queue.
`default_nettype none

package pctq_pkg;

   // Request codes
   typedef enum logic [1:0] {
      ACT_SEND = 2'd0,
      ACT_DONE = 2'd1,
      ACT_TICK = 2'd2
   } action_type;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_DROP = 2'd2
   } status_type;

   // One CAN message: header plus eight data bytes
   typedef struct packed {
      logic [28:0] id;
      logic [3:0]  len;
      logic        extended;
      logic        remote;
      logic [31:0] data_low;
      logic [31:0] data_high;
   } msg_type;

   localparam int          INTERVAL_W = 16;
   localparam int          COUNT_W    = 4;
   localparam logic [15:0] TICK_MAX   = 16'hFFFF;

endpackage

`default_nettype wire

// File: rtl/paced_can_transmit_queue.sv
// Paced CAN transmit queue, top level: input stage, decision logic, result stage.
// Depends on pctq_pkg, pctq_ring and paced_can_transmit_queue_assert.svh.
//
//   channel   direction  handshake              beat
//   csr_      in         csr_valid / csr_ready  tx_interval write
//   req_      in         req_valid / req_stall  send, transmit-done or tick
//   rsp_      out        rsp_valid / rsp_stall  status, launched message, count
//
// One beat per cycle while rsp_stall lets the result drain; each result passes through
// the input register and the result register around one decision pass.
// The ring head is read from a registered memory port, one slot per cycle.
// Synchronous reset clears pointers, tick count, interval and valids; the ring
// contents are not cleared. A held rsp_stall freezes the result, then raises
// req_stall once the input register is also occupied. csr_ready stays high.
`default_nettype none

module paced_can_transmit_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire         clock,
   input  wire         reset,
   // configuration
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [15:0] csr_tx_interval,
   // requests
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_action,
   input  wire  [28:0] req_msg_id,
   input  wire  [3:0]  req_msg_len,
   input  wire         req_msg_extended,
   input  wire         req_msg_remote,
   input  wire  [31:0] req_msg_data_low,
   input  wire  [31:0] req_msg_data_high,
   input  wire         req_hw_buffer_free,
   // results
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_launch,
   output logic [28:0] rsp_out_id,
   output logic [3:0]  rsp_out_len,
   output logic        rsp_out_extended,
   output logic        rsp_out_remote,
   output logic [31:0] rsp_out_data_low,
   output logic [31:0] rsp_out_data_high,
   output logic [3:0]  rsp_queued_count
);

`include "paced_can_transmit_queue_assert.svh"

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = (PTR_W + 1 > pctq_pkg::COUNT_W) ? PTR_W + 1 : pctq_pkg::COUNT_W;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   // Control state
   logic [pctq_pkg::INTERVAL_W-1:0] interval_ff;
   logic [15:0]                     tick_ff, tick_in, tick_inc;
   logic [PTR_W-1:0]                rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]                wr_ptr_ff, wr_ptr_in;

   // Input stage
   logic                   s1_valid_ff;
   pctq_pkg::action_type   s1_action_ff;
   pctq_pkg::msg_type      s1_msg_ff;
   logic                   s1_hw_free_ff;

   // Result stage
   logic                   rsp_valid_ff;
   pctq_pkg::status_type   rsp_status_ff, status_in;
   logic                   rsp_launch_ff, launch_in;
   pctq_pkg::msg_type      rsp_msg_ff, msg_in;
   logic [pctq_pkg::COUNT_W-1:0] rsp_count_ff;

   // Decision signals
   logic                   advance, empty, full, no_pace, push, pop;
   logic [CNT_W-1:0]       wr_x, rd_x, count_after;
   logic [PTR_W-1:0]       rd_addr;
   logic                   wr_en;
   pctq_pkg::msg_type      head_msg, req_msg;

   assign csr_ready = 1'b1;

   // Advance the input stage when the result register is free or draining
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !(!rsp_valid_ff || !rsp_stall);

   assign empty    = (rd_ptr_ff == wr_ptr_ff);
   assign full     = (next_slot(wr_ptr_ff) == rd_ptr_ff);
   assign no_pace  = (interval_ff == '0);
   assign tick_inc = (tick_ff == pctq_pkg::TICK_MAX) ? tick_ff : tick_ff + 16'd1;

   assign req_msg.id        = req_msg_id;
   assign req_msg.len       = req_msg_len;
   assign req_msg.extended  = req_msg_extended;
   assign req_msg.remote    = req_msg_remote;
   assign req_msg.data_low  = req_msg_data_low;
   assign req_msg.data_high = req_msg_data_high;

   // Decide launch, refuse, drop, enqueue or dequeue for the staged beat
   always_comb begin
      status_in = pctq_pkg::STAT_OK;
      launch_in = 1'b0;
      msg_in    = '0;
      push      = 1'b0;
      pop       = 1'b0;
      tick_in   = tick_ff;
      case (s1_action_ff)
         pctq_pkg::ACT_SEND: begin
            if (no_pace && s1_hw_free_ff) begin
               launch_in = 1'b1;
               msg_in    = s1_msg_ff;
            end else if (full) begin
               status_in = pctq_pkg::STAT_FULL;
            end else begin
               push = 1'b1;
            end
         end
         pctq_pkg::ACT_DONE: begin
            if (no_pace && !empty) begin
               pop = 1'b1;
               if (s1_hw_free_ff) begin
                  launch_in = 1'b1;
                  msg_in    = head_msg;
               end else begin
                  status_in = pctq_pkg::STAT_DROP;
               end
            end
         end
         pctq_pkg::ACT_TICK: begin
            if (!no_pace) begin
               tick_in = tick_inc;
               if (tick_inc >= interval_ff) begin
                  tick_in = '0;
                  if (s1_hw_free_ff && !empty) begin
                     pop       = 1'b1;
                     launch_in = 1'b1;
                     msg_in    = head_msg;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Next pointers and occupancy after this beat
   assign wr_ptr_in = (advance && push) ? next_slot(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = (advance && pop)  ? next_slot(rd_ptr_ff) : rd_ptr_ff;

   assign wr_x        = CNT_W'(wr_ptr_in);
   assign rd_x        = CNT_W'(rd_ptr_in);
   assign count_after = (wr_x >= rd_x) ? wr_x - rd_x : wr_x + DEPTH_CNT - rd_x;

   assign wr_en   = advance && push && !reset;
   assign rd_addr = reset ? '0 : rd_ptr_in;

   pctq_ring #(
      .DEPTH(QUEUE_DEPTH)
   ) u_ring (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_ptr_ff),
      .wr_msg   (s1_msg_ff),
      .rd_addr  (rd_addr),
      .head_msg (head_msg)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= '0;
         tick_ff      <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            interval_ff <= csr_tx_interval;
         end
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            tick_ff      <= tick_in;
            rd_ptr_ff    <= rd_ptr_in;
            wr_ptr_ff    <= wr_ptr_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_action_ff  <= pctq_pkg::action_type'(req_action);
         s1_msg_ff     <= req_msg;
         s1_hw_free_ff <= req_hw_buffer_free;
      end
   end

   // Hold the result beat until it is taken
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= status_in;
         rsp_launch_ff <= launch_in;
         rsp_msg_ff    <= msg_in;
         rsp_count_ff  <= count_after[pctq_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_launch        = rsp_launch_ff;
   assign rsp_out_id        = rsp_msg_ff.id;
   assign rsp_out_len       = rsp_msg_ff.len;
   assign rsp_out_extended  = rsp_msg_ff.extended;
   assign rsp_out_remote    = rsp_msg_ff.remote;
   assign rsp_out_data_low  = rsp_msg_ff.data_low;
   assign rsp_out_data_high = rsp_msg_ff.data_high;
   assign rsp_queued_count  = rsp_count_ff;

   // Checks
   `PCTQ_ASSERT_IMP(a_stall_needs_full_pipe, clock, reset, req_stall, rsp_valid_ff && rsp_stall && s1_valid_ff)
   `PCTQ_ASSERT_IMP(a_refuse_only_when_full, clock, reset, rsp_valid_ff && (rsp_status_ff == pctq_pkg::STAT_FULL), next_slot(wr_ptr_ff) == rd_ptr_ff)
   `PCTQ_ASSERT_IMP(a_no_launch_zero_msg, clock, reset, rsp_valid_ff && !rsp_launch_ff, rsp_msg_ff == '0)
   `PCTQ_ASSERT_NXT(a_pop_moves_read_ptr, clock, reset, advance && pop, rd_ptr_ff != $past(rd_ptr_ff))

endmodule

`default_nettype wire

// File: rtl/pctq_ring.sv
// Message ring storage with a registered head read and write-to-read bypass.
// Depends on pctq_pkg for msg_type.
`default_nettype none

module pctq_ring #(
   parameter int DEPTH = 16
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [$clog2(DEPTH)-1:0]   wr_addr,
   input  pctq_pkg::msg_type         wr_msg,
   input  wire [$clog2(DEPTH)-1:0]   rd_addr,
   output pctq_pkg::msg_type         head_msg
);

   localparam int ADDR_W = $clog2(DEPTH);

   pctq_pkg::msg_type ring_mem [DEPTH];
   pctq_pkg::msg_type rd_data_ff;
   pctq_pkg::msg_type byp_msg_ff;
   logic              byp_hit_ff;
   logic [ADDR_W-1:0] unused_chk;

   assign unused_chk = rd_addr;

   // Write the slot and read the next head location
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_msg;
      end
      rd_data_ff <= ring_mem[unused_chk];
   end

   // Forward a write that lands on the slot being read
   always_ff @(posedge clock) begin
      byp_hit_ff <= wr_en && (wr_addr == rd_addr);
      byp_msg_ff <= wr_msg;
   end

   assign head_msg = byp_hit_ff ? byp_msg_ff : rd_data_ff;

endmodule

`default_nettype wire

// File: tb/paced_can_transmit_queue_tb.sv
// Self-checking bench for the paced CAN transmit queue: predicts every result beat,
// drives requests, pacing interval writes and result stalls with random gaps.
// Depends on pctq_pkg and the paced_can_transmit_queue RTL.
`timescale 1ns / 1ps

module paced_can_transmit_queue_tb;

   localparam int          RING_SLOTS   = 16;
   localparam int          RANDOM_ITEMS = 1550;
   localparam int          MAX_GAP      = 16;
   localparam int          SETTLE       = 6;
   localparam logic [1:0]  ACT_UNUSED   = 2'd3;

   typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_type;

   // One request beat as seen at the input port
   typedef struct packed {
      logic [1:0]        action;
      pctq_pkg::msg_type msg;
      logic              hw_free;
   } req_beat_type;

   // One result beat
   typedef struct packed {
      logic [1:0]        status;
      logic              launch;
      pctq_pkg::msg_type msg;
      logic [3:0]        count;
   } tx_result_type;

   // Launch predictor and store of pending results
   class launch_scoreboard;
      pctq_pkg::msg_type ring_slot [RING_SLOTS];
      logic [3:0]        rd_ptr;
      logic [3:0]        wr_ptr;
      logic [15:0]       tick_cnt;
      logic [15:0]       interval;
      tx_result_type     pending_q [$];
      int                errors;

      function new();
         rd_ptr   = '0;
         wr_ptr   = '0;
         tick_cnt = '0;
         interval = '0;
         errors   = 0;
      endfunction

      function void set_interval(logic [15:0] value);
         interval = value;
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      // Work out the result of one accepted request and queue it
      function void note_request(req_beat_type b);
         tx_result_type r;
         logic          empty;
         logic [3:0]    wr_next;
         r        = '0;
         r.status = pctq_pkg::STAT_OK;
         empty    = (rd_ptr == wr_ptr);
         wr_next  = wr_ptr + 4'd1;
         case (b.action)
            pctq_pkg::ACT_SEND: begin
               if (interval == 16'd0 && b.hw_free) begin
                  r.launch = 1'b1;
                  r.msg    = b.msg;
               end else if (wr_next == rd_ptr) begin
                  r.status = pctq_pkg::STAT_FULL;
               end else begin
                  ring_slot[wr_ptr] = b.msg;
                  wr_ptr = wr_next;
               end
            end
            pctq_pkg::ACT_DONE: begin
               // unpaced completion pops the head; busy buffer loses it
               if (interval == 16'd0 && !empty) begin
                  if (b.hw_free) begin
                     r.launch = 1'b1;
                     r.msg    = ring_slot[rd_ptr];
                  end else begin
                     r.status = pctq_pkg::STAT_DROP;
                  end
                  rd_ptr = rd_ptr + 4'd1;
               end
            end
            pctq_pkg::ACT_TICK: begin
               if (interval != 16'd0) begin
                  if (tick_cnt != pctq_pkg::TICK_MAX) tick_cnt = tick_cnt + 16'd1;
                  if (tick_cnt >= interval) begin
                     if (b.hw_free && !empty) begin
                        r.launch = 1'b1;
                        r.msg    = ring_slot[rd_ptr];
                        rd_ptr   = rd_ptr + 4'd1;
                     end
                     tick_cnt = '0;
                  end
               end
            end
            default: ;
         endcase
         r.count = wr_ptr - rd_ptr;
         pending_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // Compare a result beat with the oldest prediction
      function void check_result(tx_result_type got);
         tx_result_type want;
         if (pending_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, actual %0h", $time, got);
            return;
         end
         want = pending_q.pop_front();
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("launch", 64'(want.launch), 64'(got.launch));
         compare_field("out_id", 64'(want.msg.id), 64'(got.msg.id));
         compare_field("out_len", 64'(want.msg.len), 64'(got.msg.len));
         compare_field("out_extended", 64'(want.msg.extended), 64'(got.msg.extended));
         compare_field("out_remote", 64'(want.msg.remote), 64'(got.msg.remote));
         compare_field("out_data_low", 64'(want.msg.data_low), 64'(got.msg.data_low));
         compare_field("out_data_high", 64'(want.msg.data_high), 64'(got.msg.data_high));
         compare_field("queued_count", 64'(want.count), 64'(got.count));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic [15:0] csr_tx_interval = '0;
   logic        req_valid = 1'b0;
   wire         req_stall;
   logic [1:0]  req_action = pctq_pkg::ACT_SEND;
   logic [28:0] req_msg_id = '0;
   logic [3:0]  req_msg_len = '0;
   logic        req_msg_extended = 1'b0;
   logic        req_msg_remote = 1'b0;
   logic [31:0] req_msg_data_low = '0;
   logic [31:0] req_msg_data_high = '0;
   logic        req_hw_buffer_free = 1'b0;
   wire         rsp_valid;
   logic        rsp_stall = 1'b0;
   wire  [1:0]  rsp_status;
   wire         rsp_launch;
   wire  [28:0] rsp_out_id;
   wire  [3:0]  rsp_out_len;
   wire         rsp_out_extended;
   wire         rsp_out_remote;
   wire  [31:0] rsp_out_data_low;
   wire  [31:0] rsp_out_data_high;
   wire  [3:0]  rsp_queued_count;

   launch_scoreboard sb = new();
   bit sender_burst = 1'b0;
   bit sink_burst   = 1'b0;

   paced_can_transmit_queue DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_tx_interval   (csr_tx_interval),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_msg_id        (req_msg_id),
      .req_msg_len       (req_msg_len),
      .req_msg_extended  (req_msg_extended),
      .req_msg_remote    (req_msg_remote),
      .req_msg_data_low  (req_msg_data_low),
      .req_msg_data_high (req_msg_data_high),
      .req_hw_buffer_free(req_hw_buffer_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_launch        (rsp_launch),
      .rsp_out_id        (rsp_out_id),
      .rsp_out_len       (rsp_out_len),
      .rsp_out_extended  (rsp_out_extended),
      .rsp_out_remote    (rsp_out_remote),
      .rsp_out_data_low  (rsp_out_data_low),
      .rsp_out_data_high (rsp_out_data_high),
      .rsp_queued_count  (rsp_queued_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop for a hung handshake
   initial begin
      #1_000_000;
      $display("paced_can_transmit_queue verification failed");
      $finish;
   end

   // Accept result beats, then hold stall for a random count
   initial begin : result_sink
      int            stall_left;
      int            taken;
      tx_result_type got;
      stall_left = 0;
      taken      = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.status        = rsp_status;
            got.launch        = rsp_launch;
            got.msg.id        = rsp_out_id;
            got.msg.len       = rsp_out_len;
            got.msg.extended  = rsp_out_extended;
            got.msg.remote    = rsp_out_remote;
            got.msg.data_low  = rsp_out_data_low;
            got.msg.data_high = rsp_out_data_high;
            got.count         = rsp_queued_count;
            sb.check_result(got);
            taken++;
            if (taken % 32 == 0) sink_burst = ($urandom_range(0, 3) == 0);
            stall_left = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic int draw_gap();
      return sender_burst ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic req_beat_type make_beat(logic [1:0] act, logic hw_free);
      req_beat_type b;
      b.action            = act;
      b.hw_free           = hw_free;
      b.msg.id            = 29'($urandom);
      b.msg.len           = 4'($urandom);
      b.msg.extended      = 1'($urandom);
      b.msg.remote        = 1'($urandom);
      b.msg.data_low      = $urandom;
      b.msg.data_high     = $urandom;
      return b;
   endfunction

   // Pick an action and buffer state leaning toward filling, draining or balancing the ring
   function automatic req_beat_type random_item(logic [15:0] interval, lean_type lean);
      int         send_pct;
      int         roll;
      logic [1:0] act;
      logic       hw_free;
      send_pct = (lean == LEAN_FILL) ? 85 : (lean == LEAN_DRAIN) ? 15 : 50;
      roll     = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 4) act = ACT_UNUSED;
      else if (roll < send_pct) act = pctq_pkg::ACT_SEND;
      else if (roll < 97) act = (interval == 16'd0) ? pctq_pkg::ACT_DONE : pctq_pkg::ACT_TICK;
      else act = (interval == 16'd0) ? pctq_pkg::ACT_TICK : pctq_pkg::ACT_DONE;
      if (act == pctq_pkg::ACT_SEND && lean == LEAN_FILL) hw_free = ($urandom_range(0, 9) == 0);
      else hw_free = ($urandom_range(0, 3) != 0);
      return make_beat(act, hw_free);
   endfunction

   function automatic bit is_ignored(req_beat_type b, logic [15:0] interval);
      return (b.action == ACT_UNUSED) ||
             (b.action == pctq_pkg::ACT_TICK && interval == 16'd0) ||
             (b.action == pctq_pkg::ACT_DONE && interval != 16'd0);
   endfunction

   // Present one request beat after a gap and hold it until accepted
   task automatic drive_request(input req_beat_type b, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_action         <= b.action;
      req_msg_id         <= b.msg.id;
      req_msg_len        <= b.msg.len;
      req_msg_extended   <= b.msg.extended;
      req_msg_remote     <= b.msg.remote;
      req_msg_data_low   <= b.msg.data_low;
      req_msg_data_high  <= b.msg.data_high;
      req_hw_buffer_free <= b.hw_free;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(b);
   endtask

   // Hold requests off until every predicted result has come out
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_interval(input logic [15:0] value);
      csr_valid       <= 1'b1;
      csr_tx_interval <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_interval(value);
   endtask

   initial begin : stimulus
      req_beat_type b;
      int           counted;
      int           phase;
      int           blk;
      int           k;
      lean_type     lean;
      logic [15:0]  phase_interval;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Unpaced: direct launches at field extremes, then noise that is ignored
      b = make_beat(pctq_pkg::ACT_SEND, 1'b1);
      b.msg = '1;
      drive_request(b, 0);
      b = make_beat(pctq_pkg::ACT_SEND, 1'b1);
      b.msg = '0;
      drive_request(b, 0);
      drive_request(make_beat(pctq_pkg::ACT_DONE, 1'b1), 0);
      drive_request(make_beat(pctq_pkg::ACT_TICK, 1'b1), 1);
      drive_request(make_beat(ACT_UNUSED, 1'b1), 0);

      // Queue three behind a busy buffer, bypass them, then pop: launch, drop, launch
      repeat (3) drive_request(make_beat(pctq_pkg::ACT_SEND, 1'b0), draw_gap());
      drive_request(make_beat(pctq_pkg::ACT_SEND, 1'b1), 0);
      drive_request(make_beat(pctq_pkg::ACT_DONE, 1'b1), 0);
      drive_request(make_beat(pctq_pkg::ACT_DONE, 1'b0), 2);
      drive_request(make_beat(pctq_pkg::ACT_DONE, 1'b1), 0);

      // Widest interval: ticks only count, completions are ignored
      drain_pipeline();
      write_interval(16'hFFFF);
      repeat (2) drive_request(make_beat(pctq_pkg::ACT_SEND, 1'b1), 0);
      drive_request(make_beat(pctq_pkg::ACT_TICK, 1'b1), 0);
      drive_request(make_beat(pctq_pkg::ACT_DONE, 1'b1), 0);

      // Lowered interval fires on the next tick; a busy buffer still restarts the count
      drain_pipeline();
      write_interval(16'd1);
      drive_request(make_beat(pctq_pkg::ACT_TICK, 1'b0), 0);
      drive_request(make_beat(pctq_pkg::ACT_TICK, 1'b1), 0);
      drive_request(make_beat(pctq_pkg::ACT_TICK, 1'b1), 3);
      drive_request(make_beat(pctq_pkg::ACT_TICK, 1'b1), 0);

      // Random phases, each under its own interval
      counted = 0;
      phase   = 0;
      while (counted < RANDOM_ITEMS) begin
         case (phase % 8)
            0:       phase_interval = 16'd0;
            1:       phase_interval = 16'd3;
            2:       phase_interval = 16'd0;
            3:       phase_interval = 16'd1;
            4:       phase_interval = 16'hFFFF;
            5:       phase_interval = 16'd2;
            6:       phase_interval = 16'($urandom_range(1, 8));
            default: phase_interval = 16'($urandom_range(0, 65535));
         endcase
         drain_pipeline();
         write_interval(phase_interval);
         for (blk = 0; blk < 7 && counted < RANDOM_ITEMS; blk++) begin
            lean         = lean_type'($urandom_range(0, 2));
            sender_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0) drain_pipeline();
            for (k = 0; k < 24; k++) begin
               b = random_item(phase_interval, lean);
               drive_request(b, draw_gap());
               if (!is_ignored(b, phase_interval)) counted++;
            end
         end
         phase++;
      end

      // Let the last results out, then let the bench settle
      drain_pipeline();
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("paced_can_transmit_queue verification clean");
      end else begin
         $display("paced_can_transmit_queue verification failed");
      end
      $finish;
   end

endmodule
